FILE: src/mle_pkg.sv
package mle_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int DIV_STEPS  = DATA_WIDTH;

    typedef enum logic [5:0] {
        OP_ADD   = 6'd0,  OP_ADDU  = 6'd1,  OP_ADDIU = 6'd2,  OP_SUB  = 6'd3,
        OP_SUBU  = 6'd4,  OP_MUL   = 6'd5,  OP_MULU  = 6'd6,  OP_DIV  = 6'd7,
        OP_DIVU  = 6'd8,  OP_XOR   = 6'd9,  OP_XORU  = 6'd10, OP_NEG  = 6'd11,
        OP_NEGU  = 6'd12, OP_REM   = 6'd13, OP_REMU  = 6'd14, OP_LI   = 6'd15,
        OP_SEQ   = 6'd16, OP_SGE   = 6'd17, OP_SGT   = 6'd18, OP_SLE  = 6'd19,
        OP_SLT   = 6'd20, OP_SNE   = 6'd21, OP_B     = 6'd22, OP_BEQ  = 6'd23,
        OP_BNE   = 6'd24, OP_BGE   = 6'd25, OP_BLE   = 6'd26, OP_BGT  = 6'd27,
        OP_BLT   = 6'd28, OP_BEQZ  = 6'd29, OP_BNEZ  = 6'd30, OP_BLEZ = 6'd31,
        OP_BGEZ  = 6'd32, OP_BGTZ  = 6'd33, OP_BLTZ  = 6'd34, OP_J    = 6'd35,
        OP_JR    = 6'd36, OP_JAL   = 6'd37, OP_JALR  = 6'd38, OP_LA   = 6'd39,
        OP_LB    = 6'd40, OP_LH    = 6'd41, OP_LW    = 6'd42, OP_SB   = 6'd43,
        OP_SH    = 6'd44, OP_SW    = 6'd45, OP_MOVE  = 6'd46, OP_MFHI = 6'd47,
        OP_MFLO  = 6'd48
    } op_t;

    // how the last stage forms the result
    typedef enum logic [1:0] {
        K_PLAIN = 2'd0,
        K_MUL   = 2'd1,
        K_DIV   = 2'd2,
        K_REM   = 2'd3
    } kind_t;

    typedef struct packed {
        logic [5:0]            cmd;
        logic [DATA_WIDTH-1:0] operand_a;
        logic [DATA_WIDTH-1:0] operand_b;
        logic [DATA_WIDTH-1:0] store_value;
        logic [DATA_WIDTH-1:0] label_address;
        logic                  predicted_taken;
        logic                  want_high;
        logic                  absolute_mode;
        logic [DATA_WIDTH-1:0] hi_in;
        logic [DATA_WIDTH-1:0] lo_in;
    } in_req_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] result_low;
        logic [DATA_WIDTH-1:0] result_high;
        logic                  branch_condition;
        logic                  mispredict;
        logic [DATA_WIDTH-1:0] redirect_address;
        logic                  suppress_write;
        logic                  link_write;
        logic                  divide_by_zero;
    } out_req_t;

    // divider working set for one step
    typedef struct packed {
        logic [DATA_WIDTH-1:0] rem;
        logic [DATA_WIDTH-1:0] quo;
        logic [DATA_WIDTH-1:0] dsor;
    } div_t;

    // data that rides alongside the divider
    typedef struct packed {
        kind_t                   kind;
        logic                    want_high;
        logic                    neg_q;
        logic                    neg_r;
        logic [2*DATA_WIDTH-1:0] prod;
        out_req_t                plain;
    } side_t;

endpackage

FILE: src/mle_div_step.sv
module mle_div_step (
    input  logic          clk,
    input  logic          advance,
    input  mle_pkg::div_t din,
    output mle_pkg::div_t dout
);

    logic [mle_pkg::DATA_WIDTH:0]   trial;
    logic [mle_pkg::DATA_WIDTH:0]   diff;
    mle_pkg::div_t                  dout_next;
    mle_pkg::div_t                  dout_reg;

    // one restoring step: shift in next dividend bit, subtract if it fits
    always_comb
    begin
        trial = {din.rem, din.quo[mle_pkg::DATA_WIDTH-1]};
        diff  = trial - {1'b0, din.dsor};
        dout_next.dsor = din.dsor;
        if (!diff[mle_pkg::DATA_WIDTH])
        begin
            dout_next.rem = diff[mle_pkg::DATA_WIDTH-1:0];
            dout_next.quo = {din.quo[mle_pkg::DATA_WIDTH-2:0], 1'b1};
        end
        else
        begin
            dout_next.rem = trial[mle_pkg::DATA_WIDTH-1:0];
            dout_next.quo = {din.quo[mle_pkg::DATA_WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

FILE: src/mips_like_execute_unit.sv
// Execute stage: takes one decoded instruction per cycle while the output is not stalled
// and returns one result per instruction, in order. Every instruction passes the same
// pipeline of 34 register stages (decode, multiply and operand setup; 32 one-bit divide
// steps; result select). The request loads the first stage at the edge that accepts it.
// Stalling the output freezes the whole pipeline; no request is lost or repeated.
module mips_like_execute_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  mle_pkg::in_req_t   in_req,
    output logic               out_valid,
    input  logic               out_stall,
    output mle_pkg::out_req_t  out_req
);

    localparam int W = mle_pkg::DATA_WIDTH;
    localparam int N = mle_pkg::DIV_STEPS;

    logic                 advance;
    logic [N:0]           valid_reg;
    logic                 out_valid_reg;
    mle_pkg::out_req_t    out_req_reg;
    mle_pkg::out_req_t    out_req_next;
    mle_pkg::side_t       side_reg [N+1];
    mle_pkg::side_t       side_next;
    mle_pkg::div_t        div_reg;
    mle_pkg::div_t        div_next;
    mle_pkg::div_t        div_chain [N+1];

    logic [W-1:0]         a, b, addr, ma, mb, q, r;
    logic                 cond, slt_ab, slt_ba, sgn_mul, sgn_div, dz;
    logic [2*W+1:0]       prod_full;

    assign advance   = !(out_valid_reg && out_stall);
    assign in_stall  = !advance;
    assign out_valid = out_valid_reg;
    assign out_req   = out_req_reg;

    // first stage: decode, simple ops, multiply, divider setup
    always_comb
    begin
        a        = in_req.operand_a;
        b        = in_req.operand_b;
        addr     = in_req.absolute_mode ? in_req.label_address : a + b;
        slt_ab   = $signed(a) < $signed(b);
        slt_ba   = $signed(b) < $signed(a);
        sgn_mul  = (in_req.cmd == mle_pkg::OP_MUL);
        sgn_div  = (in_req.cmd == mle_pkg::OP_DIV) || (in_req.cmd == mle_pkg::OP_REM);
        dz       = (b == '0);
        prod_full = 66'($signed({sgn_mul & a[W-1], a}) * $signed({sgn_mul & b[W-1], b}));
        ma       = (sgn_div && a[W-1]) ? W'(0) - a : a;
        mb       = (sgn_div && b[W-1]) ? W'(0) - b : b;
        cond     = 1'b0;

        side_next           = '0;
        side_next.kind      = mle_pkg::K_PLAIN;
        side_next.want_high = in_req.want_high;
        side_next.prod      = prod_full[2*W-1:0];

        div_next.rem  = '0;
        div_next.quo  = dz ? a : ma;
        div_next.dsor = mb;

        case (in_req.cmd)
            mle_pkg::OP_ADD, mle_pkg::OP_ADDU, mle_pkg::OP_ADDIU:
                side_next.plain.result_low = a + b;
            mle_pkg::OP_SUB, mle_pkg::OP_SUBU:
                side_next.plain.result_low = a - b;
            mle_pkg::OP_MUL, mle_pkg::OP_MULU:
                side_next.kind = mle_pkg::K_MUL;
            mle_pkg::OP_DIV, mle_pkg::OP_DIVU, mle_pkg::OP_REM, mle_pkg::OP_REMU:
            begin
                side_next.kind = (in_req.cmd == mle_pkg::OP_REM ||
                                  in_req.cmd == mle_pkg::OP_REMU)
                                 ? mle_pkg::K_REM : mle_pkg::K_DIV;
                side_next.neg_q = sgn_div && !dz && (a[W-1] != b[W-1]);
                side_next.neg_r = sgn_div && !dz && a[W-1];
                side_next.plain.divide_by_zero = dz;
            end
            mle_pkg::OP_XOR, mle_pkg::OP_XORU:
                side_next.plain.result_low = a ^ b;
            mle_pkg::OP_NEG, mle_pkg::OP_NEGU:
                side_next.plain.result_low = W'(0) - a;
            mle_pkg::OP_LI:
                side_next.plain.result_low = b;
            mle_pkg::OP_SEQ, mle_pkg::OP_SGE, mle_pkg::OP_SGT,
            mle_pkg::OP_SLE, mle_pkg::OP_SLT, mle_pkg::OP_SNE:
            begin
                case (in_req.cmd)
                    mle_pkg::OP_SEQ: cond = (a == b);
                    mle_pkg::OP_SGE: cond = !slt_ab;
                    mle_pkg::OP_SGT: cond = slt_ba;
                    mle_pkg::OP_SLE: cond = !slt_ba;
                    mle_pkg::OP_SLT: cond = slt_ab;
                    default:         cond = (a != b);
                endcase
                side_next.plain.branch_condition = cond;
                side_next.plain.result_low       = {{(W-1){1'b0}}, cond};
            end
            mle_pkg::OP_B, mle_pkg::OP_J, mle_pkg::OP_JR:
                side_next.plain.suppress_write = 1'b1;
            mle_pkg::OP_JAL, mle_pkg::OP_JALR:
            begin
                side_next.plain.result_low = b;
                side_next.plain.link_write = 1'b1;
            end
            mle_pkg::OP_BEQ, mle_pkg::OP_BNE, mle_pkg::OP_BGE, mle_pkg::OP_BLE,
            mle_pkg::OP_BGT, mle_pkg::OP_BLT, mle_pkg::OP_BEQZ, mle_pkg::OP_BNEZ,
            mle_pkg::OP_BLEZ, mle_pkg::OP_BGEZ, mle_pkg::OP_BGTZ, mle_pkg::OP_BLTZ:
            begin
                case (in_req.cmd)
                    mle_pkg::OP_BEQ:  cond = (a == b);
                    mle_pkg::OP_BNE:  cond = (a != b);
                    mle_pkg::OP_BGE:  cond = !slt_ab;
                    mle_pkg::OP_BLE:  cond = !slt_ba;
                    mle_pkg::OP_BGT:  cond = slt_ba;
                    mle_pkg::OP_BLT:  cond = slt_ab;
                    mle_pkg::OP_BEQZ: cond = (a == '0);
                    mle_pkg::OP_BNEZ: cond = (a != '0);
                    mle_pkg::OP_BLEZ: cond = (a == '0) || a[W-1];
                    mle_pkg::OP_BGEZ: cond = !a[W-1];
                    mle_pkg::OP_BGTZ: cond = (a != '0) && !a[W-1];
                    default:          cond = a[W-1];
                endcase
                side_next.plain.branch_condition = cond;
                side_next.plain.result_low       = {{(W-1){1'b0}}, cond};
                if (cond == in_req.predicted_taken)
                begin
                    side_next.plain.suppress_write = 1'b1;
                end
                else
                begin
                    side_next.plain.mispredict       = 1'b1;
                    side_next.plain.redirect_address = in_req.label_address;
                end
            end
            mle_pkg::OP_LA:
            begin
                side_next.plain.result_low  = addr;
                side_next.plain.result_high = addr;
            end
            mle_pkg::OP_LB, mle_pkg::OP_LH, mle_pkg::OP_LW:
                side_next.plain.result_high = addr;
            mle_pkg::OP_SB, mle_pkg::OP_SH, mle_pkg::OP_SW:
            begin
                side_next.plain.result_low     = in_req.store_value;
                side_next.plain.result_high    = addr;
                side_next.plain.suppress_write = 1'b1;
            end
            mle_pkg::OP_MOVE: side_next.plain.result_low = a;
            mle_pkg::OP_MFHI: side_next.plain.result_low = in_req.hi_in;
            mle_pkg::OP_MFLO: side_next.plain.result_low = in_req.lo_in;
            default: ;
        endcase
    end

    // first stage registers, sideband shift line and output register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side_reg[0] <= side_next;
            div_reg     <= div_next;
            for (int i = 1; i <= N; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
            out_req_reg <= out_req_next;
        end
    end

    assign div_chain[0] = div_reg;

    // one divide bit per stage
    for (genvar g = 0; g < N; g++)
    begin : g_div
        mle_div_step u_step (
            .clk     (clk),
            .advance (advance),
            .din     (div_chain[g]),
            .dout    (div_chain[g+1])
        );
    end

    // final stage: sign fixup and result select
    always_comb
    begin
        q = side_reg[N].neg_q ? W'(0) - div_chain[N].quo : div_chain[N].quo;
        r = side_reg[N].neg_r ? W'(0) - div_chain[N].rem : div_chain[N].rem;
        out_req_next = side_reg[N].plain;
        case (side_reg[N].kind)
            mle_pkg::K_MUL:
            begin
                out_req_next.result_low = side_reg[N].prod[W-1:0];
                if (side_reg[N].want_high)
                begin
                    out_req_next.result_high = side_reg[N].prod[2*W-1:W];
                end
            end
            mle_pkg::K_DIV:
            begin
                out_req_next.result_low = q;
                if (side_reg[N].want_high)
                begin
                    out_req_next.result_high = r;
                end
            end
            mle_pkg::K_REM:
                out_req_next.result_low = r;
            default: ;
        endcase
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg     <= {valid_reg[N-1:0], in_valid};
            out_valid_reg <= valid_reg[N];
        end
    end

endmodule
